@@ rtl/r2p_pkg.sv @@
package r2p_pkg;

    // cordic datapath widths: coordinates scaled up to a fixed binary point
    localparam int XW = 64;
    localparam int ZW = 34;
    localparam int FRAC_TOP = 61;

    // address bits of the queue between front and back
    localparam int QUEUE_AW = 2;

    // round(atan(2^-i) * 2^32 / (2*pi)), units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // what the front found about a point
    typedef enum logic [2:0] {
        CL_CORDIC,
        CL_ZERO,
        CL_HALF,
        CL_UP,
        CL_DOWN
    } t_class;

    typedef struct packed {
        t_class cls;
        logic   neg;
    } t_front_ctl;

endpackage

@@ rtl/r2p_front.sv @@
module r2p_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic                          i_full,
    output logic                          o_push,
    output logic signed [COORD_WIDTH:0]   o_x_s,
    output logic signed [COORD_WIDTH:0]   o_y_s,
    output r2p_pkg::t_front_ctl           o_ctl
);

    logic                        r_valid;
    logic signed [COORD_WIDTH:0] r_x_s;
    logic signed [COORD_WIDTH:0] r_y_s;
    r2p_pkg::t_front_ctl         r_ctl;

    logic                        w_accept;
    logic signed [COORD_WIDTH:0] w_xe;
    logic signed [COORD_WIDTH:0] w_ye;
    logic                        w_neg;
    r2p_pkg::t_class             w_cls;

    assign o_ready  = !r_valid || !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = r_valid && !i_full;

    // fold the left half plane onto the right one
    assign w_xe  = {i_x[COORD_WIDTH-1], i_x};
    assign w_ye  = {i_y[COORD_WIDTH-1], i_y};
    assign w_neg = i_x[COORD_WIDTH-1];

    // points on an axis bypass the cordic
    always_comb begin
        if (i_y == '0) begin
            w_cls = (!i_x[COORD_WIDTH-1] && i_x != '0) ? r2p_pkg::CL_ZERO
                                                        : r2p_pkg::CL_HALF;
        end else if (i_x == '0) begin
            w_cls = i_y[COORD_WIDTH-1] ? r2p_pkg::CL_DOWN : r2p_pkg::CL_UP;
        end else begin
            w_cls = r2p_pkg::CL_CORDIC;
        end
    end

    // input register, emptied into the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x_s     <= w_neg ? -w_xe : w_xe;
            r_y_s     <= w_neg ? -w_ye : w_ye;
            r_ctl.cls <= w_cls;
            r_ctl.neg <= w_neg;
        end
    end

    assign o_x_s = r_x_s;
    assign o_y_s = r_y_s;
    assign o_ctl = r_ctl;

endmodule

@@ rtl/r2p_queue.sv @@
module r2p_queue #(
    parameter int DW = 8,
    parameter int AW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);

    logic [DW-1:0] r_mem [2**AW];
    logic [AW:0]   r_wr;
    logic [AW:0]   r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    // pointers carry one wrap bit to tell full from empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

@@ rtl/r2p_cordic.sv @@
module r2p_cordic #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int STAGES      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH:0]   i_x,
    input  logic signed [COORD_WIDTH:0]   i_y,
    input  r2p_pkg::t_front_ctl           i_ctl,
    output logic signed [ANGLE_WIDTH:0]   o_angle
);

    localparam int XW = r2p_pkg::XW;
    localparam int ZW = r2p_pkg::ZW;
    localparam int SH = r2p_pkg::FRAC_TOP - COORD_WIDTH;
    localparam int S  = 32 - ANGLE_WIDTH;
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) <<< 31;
    localparam logic signed [ZW-1:0] RND    = (ZW'(1) <<< S) >>> 1;
    localparam logic signed [ZW-1:0] TOP    =
        (ZW'(3) * (ZW'(1) <<< (ANGLE_WIDTH - 2))) - ZW'(1);
    localparam logic signed [ANGLE_WIDTH:0] QUARTER =
        (ANGLE_WIDTH + 1)'(1) << (ANGLE_WIDTH - 2);
    localparam logic signed [ANGLE_WIDTH:0] HALF = QUARTER << 1;

    logic signed [XW-1:0]        r_x   [STAGES+1];
    logic signed [XW-1:0]        r_y   [STAGES+1];
    logic signed [ZW-1:0]        r_z   [STAGES+1];
    r2p_pkg::t_class             r_cls [STAGES+1];
    logic signed [ANGLE_WIDTH:0] r_angle;

    logic signed [ZW-1:0]        n_z;
    logic signed [ZW-1:0]        n_a;
    logic signed [ZW-1:0]        n_clamp;
    logic signed [ANGLE_WIDTH:0] n_angle;

    // load: scale to the fixed binary point, start angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= XW'(i_x) <<< SH;
            r_y[0]   <= XW'(i_y) <<< SH;
            r_z[0]   <= i_ctl.neg ? Z_HALF : '0;
            r_cls[0] <= i_ctl.cls;
        end
    end

    // one micro-rotation per stage, driving y toward zero
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = signed'({2'b00, r2p_pkg::ATAN_TURNS[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ANG;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ANG;
                end
                r_cls[i+1] <= r_cls[i];
            end
        end
    end

    // round to output units, clamp below three quarter turns, axis cases
    always_comb begin
        n_z     = r_z[STAGES] + RND;
        n_a     = n_z >>> S;
        n_clamp = (n_a > TOP) ? TOP : n_a;
        case (r_cls[STAGES])
            r2p_pkg::CL_ZERO: n_angle = '0;
            r2p_pkg::CL_HALF: n_angle = HALF;
            r2p_pkg::CL_UP:   n_angle = QUARTER;
            r2p_pkg::CL_DOWN: n_angle = -QUARTER;
            default:          n_angle = n_clamp[ANGLE_WIDTH:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

@@ rtl/r2p_root.sv @@
module r2p_root #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH:0]   i_x,
    input  logic signed [COORD_WIDTH:0]   i_y,
    output logic [COORD_WIDTH-1:0]        o_mag
);

    localparam int W  = COORD_WIDTH;
    localparam int NW = 2 * COORD_WIDTH;

    logic [NW-1:0] r_sqx;
    logic [NW-1:0] r_sqy;
    logic [NW-1:0] r_rem  [W+1];
    logic [NW-1:0] r_root [W+1];
    logic [W-1:0]  r_mag;

    logic [W-1:0]  w_ax;
    logic [W:0]    w_ay_full;
    logic [W-1:0]  w_ay;
    logic [NW-1:0] w_sqx;
    logic [NW-1:0] w_sqy;

    // x is already folded to be non-negative
    assign w_ax      = i_x[W-1:0];
    assign w_ay_full = i_y[W] ? -i_y : i_y;
    assign w_ay      = w_ay_full[W-1:0];
    assign w_sqx     = w_ax * w_ax;
    assign w_sqy     = w_ay * w_ay;

    // squares, then their sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx     <= w_sqx;
            r_sqy     <= w_sqy;
            r_rem[0]  <= r_sqx + r_sqy;
            r_root[0] <= '0;
        end
    end

    // restoring square root, one result bit per stage
    for (genvar k = 0; k < W; k++) begin : g_step
        localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
        logic [NW-1:0] w_t;
        assign w_t = r_root[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k] >= w_t) begin
                    r_rem[k+1]  <= r_rem[k] - w_t;
                    r_root[k+1] <= (r_root[k] >> 1) + BIT;
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k] >> 1;
                end
            end
        end
    end

    // round to nearest: the remainder beyond the root means round up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= (r_rem[W] > r_root[W]) ? r_root[W][W-1:0] + W'(1)
                                            : r_root[W][W-1:0];
        end
    end

    assign o_mag = r_mag;

endmodule

@@ rtl/r2p_back.sv @@
module r2p_back #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int STAGES      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  logic signed [COORD_WIDTH:0]   i_x_s,
    input  logic signed [COORD_WIDTH:0]   i_y_s,
    input  r2p_pkg::t_front_ctl           i_ctl,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COORD_WIDTH-1:0]        o_mag,
    output logic signed [ANGLE_WIDTH:0]   o_angle
);

    localparam int LC = STAGES + 2;
    localparam int LR = COORD_WIDTH + 3;
    localparam int L  = (LC > LR) ? LC : LR;
    localparam int PC = L - LC;
    localparam int PR = L - LR;

    logic [L-1:0]                r_vld;
    logic                        w_en;
    logic signed [ANGLE_WIDTH:0] w_angle;
    logic [COORD_WIDTH-1:0]      w_mag;

    // the whole pipeline moves unless the last stage is held
    assign w_en    = !r_vld[L-1] || i_ready;
    assign o_pop   = w_en && !i_q_empty;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], o_pop};
        end
    end

    r2p_cordic #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .STAGES      (STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (i_x_s),
        .i_y     (i_y_s),
        .i_ctl   (i_ctl),
        .o_angle (w_angle)
    );

    r2p_root #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_root (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (i_x_s),
        .i_y   (i_y_s),
        .o_mag (w_mag)
    );

    // pad the shorter path so both results land together
    if (PC > 0) begin : g_apad
        logic signed [ANGLE_WIDTH:0] r_apad [PC];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_apad[0] <= w_angle;
                for (int j = 1; j < PC; j++) begin
                    r_apad[j] <= r_apad[j-1];
                end
            end
        end
        assign o_angle = r_apad[PC-1];
    end else begin : g_anopad
        assign o_angle = w_angle;
    end

    if (PR > 0) begin : g_mpad
        logic [COORD_WIDTH-1:0] r_mpad [PR];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_mpad[0] <= w_mag;
                for (int j = 1; j < PR; j++) begin
                    r_mpad[j] <= r_mpad[j-1];
                end
            end
        end
        assign o_mag = r_mpad[PR-1];
    end else begin : g_mnopad
        assign o_mag = w_mag;
    end

endmodule

@@ rtl/rectangular_to_polar_core.sv @@
// rectangular to polar conversion, pipelined vectoring cordic
//
// input stream (s_axis): one word per point, x and y as two's complement.
// output stream (m_axis): one word per point, rounded magnitude and angle
// in binary units (2^ANGLE_WIDTH per turn), from -1/4 up to below 3/4 turn.
// throughput: one word per cycle while m_axis_tready stays high; the cordic
// stages and the square root stages are each one register deep and all
// advance together. the longer of the cordic path and the root path sets the
// delay from input handshake to output valid; the front register and queue
// lie ahead of both paths.
// a front register classifies each point and feeds a four-word queue; the
// back pipeline pulls from it. when the receiver drops tready with a word at
// its end, the back pipeline holds its contents, the queue and front register
// keep taking words until they fill, then s_axis_tready falls.
// reset (i_rst_n low, synchronous) empties the front register, the queue
// and the pipeline; no words are in flight afterwards.
module rectangular_to_polar_core #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int STAGES      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_coord, y_coord
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // magnitude, angle
    output logic [((COORD_WIDTH+ANGLE_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);

    localparam int W      = COORD_WIDTH;
    localparam int OUT_TW = ((COORD_WIDTH + ANGLE_WIDTH + 1 + 7) / 8) * 8;
    localparam int CW     = $bits(r2p_pkg::t_front_ctl);
    localparam int QW     = CW + 2 * (W + 1);
    localparam logic signed [ANGLE_WIDTH:0] QUARTER =
        (ANGLE_WIDTH + 1)'(1) << (ANGLE_WIDTH - 2);
    localparam logic signed [ANGLE_WIDTH:0] HALF_TURN = QUARTER << 1;
    localparam logic signed [ANGLE_WIDTH:0] TOP_ANGLE =
        HALF_TURN + QUARTER - (ANGLE_WIDTH + 1)'(1);

    logic signed [W-1:0]         w_in_x;
    logic signed [W-1:0]         w_in_y;
    logic                        w_push;
    logic                        w_full;
    logic                        w_empty;
    logic                        w_pop;
    logic signed [W:0]           w_f_x;
    logic signed [W:0]           w_f_y;
    r2p_pkg::t_front_ctl         w_f_ctl;
    logic [QW-1:0]               w_q_in;
    logic [QW-1:0]               w_q_out;
    logic signed [W:0]           w_b_x;
    logic signed [W:0]           w_b_y;
    r2p_pkg::t_front_ctl         w_b_ctl;
    logic [W-1:0]                w_mag;
    logic signed [ANGLE_WIDTH:0] w_angle;

    assign w_in_x = s_axis_tdata[W-1:0];
    assign w_in_y = s_axis_tdata[2*W-1:W];

    r2p_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (w_in_x),
        .i_y     (w_in_y),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_x_s   (w_f_x),
        .o_y_s   (w_f_y),
        .o_ctl   (w_f_ctl)
    );

    // queue word: folded x, folded y, classification
    assign w_q_in = {w_f_ctl, w_f_y, w_f_x};

    r2p_queue #(
        .DW (QW),
        .AW (r2p_pkg::QUEUE_AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    assign w_b_x   = w_q_out[W:0];
    assign w_b_y   = w_q_out[2*W+1:W+1];
    assign w_b_ctl = r2p_pkg::t_front_ctl'(w_q_out[QW-1:2*W+2]);

    r2p_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .STAGES      (STAGES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .o_pop     (w_pop),
        .i_x_s     (w_b_x),
        .i_y_s     (w_b_y),
        .i_ctl     (w_b_ctl),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_mag     (w_mag),
        .o_angle   (w_angle)
    );

    assign m_axis_tdata = OUT_TW'({w_angle, w_mag});

    // only the origin has zero length, and its angle is half a turn
    a_origin_half_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_mag == '0) |-> (w_angle == HALF_TURN))
        else $error("origin word without half-turn angle");

    // clamp and fold keep the angle inside its range
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_angle >= -QUARTER && w_angle <= TOP_ANGLE))
        else $error("angle out of range");

    // after a pop of a non-empty queue, it is never seen full and empty at once
    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_empty) |=> !($past(w_full) && w_full && w_empty))
        else $error("queue status inconsistent after pop");

endmodule
